// ===== hw/rtl/ras_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ras_pkg;

    localparam int unsigned IN_KEY_W = 32;
    localparam int unsigned IDX_W    = 5;

    typedef enum logic
    {
        ST_LOAD,
        ST_EMIT
    } ras_state_t;

    typedef struct packed
    {
        logic ins;
        logic shift;
    } ras_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ras_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ras_key_if;
    logic        valid;
    logic        ready;
    logic [31:0] sort_key;
    logic        last_key;

    modport source (output valid, output sort_key, output last_key, input ready);
    modport sink   (input valid, input sort_key, input last_key, output ready);
endinterface

interface ras_idx_if;
    logic       valid;
    logic       ready;
    logic [4:0] city_index;
    logic       last_result;
    logic       overflow;

    modport source (output valid, output city_index, output last_result, output overflow,
                    input ready);
    modport sink   (input valid, input city_index, input last_result, input overflow,
                    output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ras_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ras_cell #(
    parameter int unsigned KW = 32
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  ras_pkg::ras_ctl_t      ctl,
    input  wire [KW-1:0]           new_key,
    input  wire [ras_pkg::IDX_W-1:0] new_idx,
    input  wire                    left_gt,
    input  wire                    left_valid,
    input  wire [KW-1:0]           left_key,
    input  wire [ras_pkg::IDX_W-1:0] left_idx,
    input  wire                    right_valid,
    input  wire [KW-1:0]           right_key,
    input  wire [ras_pkg::IDX_W-1:0] right_idx,
    output logic                   gt,
    output logic                   valid,
    output logic [KW-1:0]          key,
    output logic [ras_pkg::IDX_W-1:0] idx
);
    import ras_pkg::*;

    logic              valid_reg, valid_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;

    // empty cells count as larger than any key
    assign gt    = !valid_reg || (key_reg > new_key);
    assign valid = valid_reg;
    assign key   = key_reg;
    assign idx   = idx_reg;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        if (ctl.shift)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            idx_next   = right_idx;
        end
        else if (ctl.ins && gt)
        begin
            valid_next = valid_reg | left_valid;
            key_next   = left_gt ? left_key : new_key;
            idx_next   = left_gt ? left_idx : new_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        idx_reg <= idx_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/random_key_argsort_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Random-key argsort. Keys arrive one beat per cycle on keys; the arrival
// position within a group is the key's index. Each key is inserted into a
// chain of MAX_KEYS cells kept in ascending order (equal keys keep arrival
// order). After the beat with last_key the chain shifts toward cell 0 and
// perm gives one index per cycle while perm.ready is high, the final one
// flagged by last_result; keys stays stalled until the last index is
// taken. Keys beyond MAX_KEYS are dropped and reported on overflow. Only
// the low KEY_BITS bits of sort_key take part in the compare.
module random_key_argsort_top #(
    parameter int unsigned MAX_KEYS = 32,
    parameter int unsigned KEY_BITS = 32
) (
    input  wire     clk,
    input  wire     rst_n,
    ras_key_if.sink   keys,
    ras_idx_if.source perm
);
    import ras_pkg::*;

    localparam int unsigned KW = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
    localparam int unsigned CW = $clog2(MAX_KEYS + 1);

    ras_state_t       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             ovf_reg, ovf_next;

    logic             accept_in;
    logic             full;
    logic             done;
    ras_ctl_t         ctl;
    logic [KW-1:0]    new_key;
    logic [IDX_W-1:0] new_idx;

    logic             gt_w    [MAX_KEYS];
    logic             valid_w [MAX_KEYS];
    logic [KW-1:0]    key_w   [MAX_KEYS];
    logic [IDX_W-1:0] idx_w   [MAX_KEYS];

    assign new_key   = keys.sort_key[KW-1:0];
    assign new_idx   = IDX_W'(count_reg);
    assign full      = (count_reg == CW'(MAX_KEYS));
    assign accept_in = keys.valid && keys.ready;
    assign done      = !valid_w[0] || (perm.ready && !valid_w[1]);

    genvar g;
    generate
        for (g = 0; g < MAX_KEYS; g++)
        begin : g_cell
            logic             l_gt, l_valid, r_valid;
            logic [KW-1:0]    l_key, r_key;
            logic [IDX_W-1:0] l_idx, r_idx;

            if (g == 0)
            begin : g_head
                assign l_gt    = 1'b0;
                assign l_valid = 1'b1;
                assign l_key   = '0;
                assign l_idx   = '0;
            end
            else
            begin : g_mid
                assign l_gt    = gt_w[g-1];
                assign l_valid = valid_w[g-1];
                assign l_key   = key_w[g-1];
                assign l_idx   = idx_w[g-1];
            end

            if (g == MAX_KEYS - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_key   = '0;
                assign r_idx   = '0;
            end
            else
            begin : g_body
                assign r_valid = valid_w[g+1];
                assign r_key   = key_w[g+1];
                assign r_idx   = idx_w[g+1];
            end

            ras_cell #(
                .KW (KW)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .new_key     (new_key),
                .new_idx     (new_idx),
                .left_gt     (l_gt),
                .left_valid  (l_valid),
                .left_key    (l_key),
                .left_idx    (l_idx),
                .right_valid (r_valid),
                .right_key   (r_key),
                .right_idx   (r_idx),
                .gt          (gt_w[g]),
                .valid       (valid_w[g]),
                .key         (key_w[g]),
                .idx         (idx_w[g])
            );
        end
    endgenerate

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept_in && keys.last_key)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (done)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        keys.ready = 1'b0;
        perm.valid = 1'b0;
        ctl.ins    = 1'b0;
        ctl.shift  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                keys.ready = 1'b1;
                ctl.ins    = keys.valid && !full;
            end
            ST_EMIT:
            begin
                perm.valid = valid_w[0];
                ctl.shift  = valid_w[0] && perm.ready;
            end
            default:
            begin
                keys.ready = 1'b0;
            end
        endcase
    end

    assign perm.city_index  = idx_w[0];
    assign perm.last_result = !valid_w[1];
    assign perm.overflow    = ovf_reg;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (state_reg == ST_EMIT && done)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
        else if (ctl.ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (accept_in && full)
        begin
            ovf_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/random_key_argsort_top_tb.sv =====
`timescale 1ns / 1ps

module random_key_argsort_top_tb;
    import ras_pkg::*;

    localparam int unsigned MAX_KEYS  = 32;
    localparam int unsigned KEY_BITS  = 32;
    localparam int          HOLD_LEN  = 300;
    localparam int          IDLE_MAX  = 2000;
    localparam int          RAND_KEYS = 70;
    localparam logic [IN_KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= IN_KEY_W) ? '1 : ((IN_KEY_W'(1) << KEY_BITS) - 1'b1);

    typedef struct packed
    {
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             ovf;
    } perm_beat_t;

    typedef struct packed
    {
        logic [31:0]      key;
        logic             last;
        logic [5:0]       rep;
        logic             has_exp;
        logic [IDX_W-1:0] exp_idx;
        logic             exp_ovf;
    } key_row_t;

    localparam int N_ROWS = 15;
    localparam key_row_t DIR_ROWS [N_ROWS] = '{
        '{32'h0000_0000, 1'b1, 6'd1,  1'b1, 5'd0, 1'b0},
        '{32'hFFFF_FFFF, 1'b1, 6'd1,  1'b1, 5'd0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 6'd1,  1'b0, 5'd0, 1'b0},
        '{32'h0000_0000, 1'b0, 6'd1,  1'b0, 5'd0, 1'b0},
        '{32'h8000_0000, 1'b0, 6'd1,  1'b0, 5'd0, 1'b0},
        '{32'h7FFF_FFFF, 1'b1, 6'd1,  1'b0, 5'd0, 1'b0},
        '{32'h0000_0005, 1'b0, 6'd2,  1'b0, 5'd0, 1'b0},
        '{32'h0000_0003, 1'b0, 6'd1,  1'b0, 5'd0, 1'b0},
        '{32'h0000_0005, 1'b0, 6'd1,  1'b0, 5'd0, 1'b0},
        '{32'hFFFF_FFFF, 1'b0, 6'd1,  1'b0, 5'd0, 1'b0},
        '{32'h0000_0003, 1'b1, 6'd1,  1'b0, 5'd0, 1'b0},
        '{32'hA5A5_A5A5, 1'b0, 6'd32, 1'b0, 5'd0, 1'b0},
        '{32'h0000_0000, 1'b1, 6'd1,  1'b0, 5'd0, 1'b0},
        '{32'h1234_5678, 1'b1, 6'd32, 1'b0, 5'd0, 1'b0},
        '{32'h5A5A_5A5A, 1'b1, 6'd1,  1'b1, 5'd0, 1'b0}
    };

    logic clk;
    logic rst_n;

    ras_key_if keys_if ();
    ras_idx_if perm_if ();

    random_key_argsort_top #(
        .MAX_KEYS (MAX_KEYS),
        .KEY_BITS (KEY_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .keys  (keys_if),
        .perm  (perm_if)
    );

    // argsort state
    logic [IN_KEY_W-1:0] ranked_keys [MAX_KEYS];
    logic [IDX_W-1:0]    ranked_idx  [MAX_KEYS];
    int unsigned         ranked_count;
    logic                dropped_key;

    perm_beat_t perm_due [$];

    logic             row_has_exp;
    logic [IDX_W-1:0] row_exp_idx;
    logic             row_exp_ovf;

    logic steady;
    logic hold_req;
    int   errors;
    int   keys_taken;
    int   beats_seen;
    int   groups_done;
    int   overflow_groups;
    int   holds_done;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        errors++;
    endtask

    task automatic argsort_step(input logic [IN_KEY_W-1:0] raw_key, input logic last);
        logic [IN_KEY_W-1:0] key;
        int                  pos;
        perm_beat_t          beat;
        key = raw_key & KEY_MASK;
        if (ranked_count >= MAX_KEYS)
        begin
            dropped_key = 1'b1;
        end
        else
        begin
            pos = ranked_count;
            while (pos > 0 && ranked_keys[pos-1] > key)
            begin
                ranked_keys[pos] = ranked_keys[pos-1];
                ranked_idx[pos]  = ranked_idx[pos-1];
                pos--;
            end
            ranked_keys[pos] = key;
            ranked_idx[pos]  = IDX_W'(ranked_count);
            ranked_count++;
        end
        if (last)
        begin
            for (int k = 0; k < ranked_count; k++)
            begin
                beat.idx  = ranked_idx[k];
                beat.last = (k + 1 == ranked_count);
                beat.ovf  = dropped_key;
                perm_due.push_back(beat);
            end
            if (dropped_key)
                overflow_groups++;
            groups_done++;
            ranked_count = 0;
            dropped_key  = 1'b0;
        end
    endtask

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic offer_key(input logic [31:0] key, input logic last, input logic has_exp,
                             input logic [IDX_W-1:0] exp_idx, input logic exp_ovf);
        while (!steady && $urandom_range(0, 99) < 15)
        begin
            keys_if.valid <= 1'b0;
            @(negedge clk);
        end
        row_has_exp = has_exp;
        row_exp_idx = exp_idx;
        row_exp_ovf = exp_ovf;
        keys_if.valid    <= 1'b1;
        keys_if.sort_key <= key;
        keys_if.last_key <= last;
        do
            @(posedge clk);
        while (!keys_if.ready);
        @(negedge clk);
    endtask

    // input side: predict on every accepted key
    initial
    begin
        perm_beat_t beat;
        forever
        begin
            @(posedge clk);
            if (rst_n && keys_if.valid && keys_if.ready)
            begin
                keys_taken++;
                if (row_has_exp)
                begin
                    beat.idx  = row_exp_idx;
                    beat.last = 1'b1;
                    beat.ovf  = row_exp_ovf;
                    perm_due.push_back(beat);
                    groups_done++;
                end
                else
                begin
                    argsort_step(keys_if.sort_key, keys_if.last_key);
                end
            end
        end
    end

    // output side: compare against oldest expectation
    initial
    begin
        perm_beat_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && perm_if.valid && perm_if.ready)
            begin
                beats_seen++;
                if (perm_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat idx=%0d last=%0b ovf=%0b",
                                              perm_if.city_index, perm_if.last_result,
                                              perm_if.overflow));
                end
                else
                begin
                    want = perm_due.pop_front();
                    if (perm_if.city_index !== want.idx)
                        report_mismatch($sformatf("city_index got %0d expected %0d",
                                                  perm_if.city_index, want.idx));
                    if (perm_if.last_result !== want.last)
                        report_mismatch($sformatf("last_result got %0b expected %0b",
                                                  perm_if.last_result, want.last));
                    if (perm_if.overflow !== want.ovf)
                        report_mismatch($sformatf("overflow got %0b expected %0b",
                                                  perm_if.overflow, want.ovf));
                end
            end
        end
    end

    // receiver
    initial
    begin
        perm_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                perm_if.ready <= 1'b0;
                repeat (HOLD_LEN - 1) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
            begin
                perm_if.ready <= steady || ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // watchdog
    initial
    begin
        int idle;
        idle = 0;
        forever
        begin
            @(posedge clk);
            if ((keys_if.valid && keys_if.ready) || (perm_if.valid && perm_if.ready))
                idle = 0;
            else
                idle++;
            if (idle >= IDLE_MAX)
            begin
                $display("timeout: no beat for %0d cycles, %0d results still due",
                         IDLE_MAX, perm_due.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        int          rand_keys;
        int          grp_len;
        logic        ties;
        logic [31:0] key;
        rst_n            = 1'b0;
        keys_if.valid    = 1'b0;
        keys_if.sort_key = '0;
        keys_if.last_key = 1'b0;
        row_has_exp      = 1'b0;
        row_exp_idx      = '0;
        row_exp_ovf      = 1'b0;
        steady           = 1'b0;
        hold_req         = 1'b0;
        errors           = 0;
        keys_taken       = 0;
        beats_seen       = 0;
        groups_done      = 0;
        overflow_groups  = 0;
        holds_done       = 0;
        ranked_count     = 0;
        dropped_key      = 1'b0;
        rand_keys        = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int r = 0; r < N_ROWS; r++)
        begin
            for (int c = 0; c < DIR_ROWS[r].rep; c++)
            begin
                offer_key(DIR_ROWS[r].key, DIR_ROWS[r].last && (c == DIR_ROWS[r].rep - 1),
                          DIR_ROWS[r].has_exp, DIR_ROWS[r].exp_idx, DIR_ROWS[r].exp_ovf);
            end
        end

        hold_req = 1'b1;
        while (rand_keys < RAND_KEYS)
        begin
            grp_len = ($urandom_range(0, 5) == 0) ? $urandom_range(MAX_KEYS - 1, MAX_KEYS + 2)
                                                  : $urandom_range(1, 10);
            ties    = ($urandom_range(0, 2) == 0);
            steady  = (rand_keys >= 20 && rand_keys < 50);
            for (int i = 0; i < grp_len; i++)
            begin
                key = ties ? 32'($urandom_range(0, 3)) : $urandom();
                if ($urandom_range(0, 15) == 0)
                    key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
                offer_key(key, i == grp_len - 1, 1'b0, '0, 1'b0);
                rand_keys++;
            end
        end
        steady = 1'b0;
        keys_if.valid <= 1'b0;

        while (perm_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d keys in %0d groups (%0d with dropped keys), %0d indices checked",
                 keys_taken, groups_done, overflow_groups, beats_seen);
        $display("long receiver hold-offs: %0d, mismatches: %0d", holds_done, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
